// ===== rtl/assert_macros.svh =====
// Assertion helpers used by gsf_back.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in any cycle where ante holds
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// prop must hold in every cycle out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("invariant check failed");

`endif

// ===== rtl/gsf_pkg.sv =====
`timescale 1ns / 1ps

package gsf_pkg;

    localparam int COORD_BITS_DEF = 14;
    localparam int MOTION_WINDOW  = 2;
    localparam int QUEUE_DEPTH    = 2;

    localparam int IDLE_W = 8;
    localparam int THR_W  = 30;
    localparam int CFG_IDX_W = 1;

    localparam logic [IDLE_W-1:0] IDLE_LIMIT_RST = 8'd45;
    localparam logic [THR_W-1:0]  MOTION_THR_RST = 30'd2500;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IDLE_LIMIT = 1'b0,
        CFG_MOTION_THR = 1'b1
    } t_cfg_idx;

endpackage

// ===== rtl/gsf_front.sv =====
`timescale 1ns / 1ps

module gsf_front #(
    parameter int COORD_BITS = gsf_pkg::COORD_BITS_DEF
) (
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_user_tracked,
    input  logic signed [COORD_BITS-1:0] i_left_hand_x,
    input  logic signed [COORD_BITS-1:0] i_left_hand_y,
    input  logic signed [COORD_BITS-1:0] i_left_hand_z,
    input  logic signed [COORD_BITS-1:0] i_right_hand_x,
    input  logic signed [COORD_BITS-1:0] i_right_hand_y,
    input  logic signed [COORD_BITS-1:0] i_right_hand_z,
    input  logic signed [COORD_BITS-1:0] i_torso_y,
    input  logic signed [COORD_BITS-1:0] i_left_hip_x,
    input  logic signed [COORD_BITS-1:0] i_left_hip_y,
    input  logic signed [COORD_BITS-1:0] i_right_hip_x,
    input  logic signed [COORD_BITS-1:0] i_right_hip_y,
    input  logic                         i_q_full,
    output logic                         o_push,
    output logic [6*COORD_BITS+1:0]      o_frame
);

    logic left_ok;
    logic right_ok;
    logic pose_ok;

    // ready pose: both hands inside the hip/torso box
    assign left_ok  = (i_left_hand_y >= i_left_hip_y) && (i_left_hand_y <= i_torso_y) &&
                      (i_left_hand_x >= i_left_hip_x) && (i_left_hand_x <= i_right_hip_x);
    assign right_ok = (i_right_hand_y >= i_right_hip_y) && (i_right_hand_y <= i_torso_y) &&
                      (i_right_hand_x >= i_left_hip_x) && (i_right_hand_x <= i_right_hip_x);
    assign pose_ok  = left_ok && right_ok;

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;
    assign o_frame    = {i_user_tracked, pose_ok,
                         i_right_hand_z, i_right_hand_y, i_right_hand_x,
                         i_left_hand_z, i_left_hand_y, i_left_hand_x};

endmodule

// ===== rtl/gsf_queue.sv =====
`timescale 1ns / 1ps

module gsf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = gsf_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/gsf_back.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gsf_back #(
    parameter int COORD_BITS = gsf_pkg::COORD_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    input  logic [gsf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [gsf_pkg::THR_W-1:0]        i_cfg_data,
    input  logic                             i_q_valid,
    input  logic [6*COORD_BITS+1:0]          i_q_frame,
    output logic                             o_q_pop,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [1:0]                       o_phase,
    output logic                             o_frame_kept,
    output logic                             o_sign_started,
    output logic                             o_sign_ended,
    output logic                             o_sentence_ended,
    output logic                             o_phase_announced
);

    localparam int CB       = COORD_BITS;
    localparam int DIFF_W   = CB + 1;
    localparam int SQ_W     = 2 * DIFF_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int THR_W    = gsf_pkg::THR_W;
    localparam int IDLE_W   = gsf_pkg::IDLE_W;
    localparam int CMP_W    = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam int TRK_BIT  = 6 * CB + 1;
    localparam int POSE_BIT = 6 * CB;
    localparam logic [1:0] FILL_FULL = 2'(gsf_pkg::MOTION_WINDOW);

    typedef enum logic [1:0] {
        PH_WAIT_TRACK = 2'd0,
        PH_WAIT_READY = 2'd1,
        PH_WAIT_MOVE  = 2'd2,
        PH_RECORD     = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        SEQ_DECIDE,
        SEQ_SQUARE,
        SEQ_SUM
    } t_seq;

    t_phase                  r_phase, n_phase;
    t_seq                    r_seq, n_seq;
    logic [IDLE_W-1:0]       r_idle, n_idle;
    logic [1:0]              r_fill, n_fill;
    logic [IDLE_W-1:0]       r_idle_limit;
    logic [THR_W-1:0]        r_thresh;
    logic                    r_out_valid, n_out_valid;
    logic [1:0]              r_out_phase, n_out_phase;
    logic                    r_kept, n_kept;
    logic                    r_started, n_started;
    logic                    r_ended, n_ended;
    logic                    r_sent, n_sent;
    logic                    r_announced, n_announced;
    logic [6*CB-1:0]         r_last, n_last;
    logic signed [DIFF_W-1:0] r_diff [6];
    logic signed [DIFF_W-1:0] n_diff [6];
    logic [SQ_W-1:0]         r_sq [6];
    logic [SQ_W-1:0]         n_sq [6];
    logic [SUM_W-1:0]        r_dist_l, n_dist_l;
    logic [SUM_W-1:0]        r_dist_r, n_dist_r;

    logic                    take;
    logic                    tracked;
    logic                    pose_ok;
    logic                    hist_move;
    logic                    full_hist;
    logic                    clear;
    logic                    keep;
    logic [IDLE_W:0]         idle_next;
    logic [1:0]              fill_base;
    logic signed [SQ_W-1:0]  d_ext [6];

    assign tracked   = i_q_frame[TRK_BIT];
    assign pose_ok   = i_q_frame[POSE_BIT];
    assign full_hist = (r_fill == FILL_FULL);
    assign take      = (r_seq == SEQ_DECIDE) && i_q_valid && (!r_out_valid || i_out_ready);
    assign o_q_pop   = take;
    assign idle_next = {1'b0, r_idle} + 1'b1;

    always_comb begin
        hist_move = (CMP_W'(r_dist_l) > CMP_W'(r_thresh)) ||
                    (CMP_W'(r_dist_r) > CMP_W'(r_thresh));
        for (int k = 0; k < 6; k++) begin
            d_ext[k] = {{DIFF_W{r_diff[k][DIFF_W-1]}}, r_diff[k]};
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_seq       = r_seq;
        n_idle      = r_idle;
        n_fill      = r_fill;
        n_last      = r_last;
        n_dist_l    = r_dist_l;
        n_dist_r    = r_dist_r;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_phase = r_out_phase;
        n_kept      = r_kept;
        n_started   = r_started;
        n_ended     = r_ended;
        n_sent      = r_sent;
        n_announced = r_announced;
        clear       = 1'b0;
        keep        = 1'b0;
        fill_base   = r_fill;
        for (int k = 0; k < 6; k++) begin
            n_diff[k] = r_diff[k];
            n_sq[k]   = SQ_W'(d_ext[k] * d_ext[k]);
        end

        unique case (r_seq)
            SEQ_DECIDE: begin
                if (take) begin
                    n_started   = 1'b0;
                    n_ended     = 1'b0;
                    n_sent      = 1'b0;
                    n_announced = 1'b0;
                    unique case (r_phase)
                        PH_WAIT_TRACK: begin
                            if (tracked) begin
                                n_phase     = PH_WAIT_READY;
                                n_announced = 1'b1;
                            end
                        end
                        PH_WAIT_READY: begin
                            if (pose_ok) begin
                                n_phase = PH_WAIT_MOVE;
                            end
                        end
                        PH_WAIT_MOVE: begin
                            if (full_hist && hist_move) begin
                                n_idle      = '0;
                                n_phase     = PH_RECORD;
                                n_announced = 1'b1;
                                clear       = 1'b1;
                                keep        = 1'b1;
                                n_started   = 1'b1;
                            end else if (idle_next > {1'b0, r_idle_limit}) begin
                                n_idle      = '0;
                                clear       = 1'b1;
                                n_phase     = PH_WAIT_READY;
                                n_announced = 1'b1;
                                n_sent      = 1'b1;
                            end else begin
                                n_idle = idle_next[IDLE_W-1:0];
                                keep   = 1'b1;
                            end
                        end
                        PH_RECORD: begin
                            if (pose_ok && full_hist && !hist_move) begin
                                n_phase = PH_WAIT_READY;
                                clear   = 1'b1;
                                n_ended = 1'b1;
                            end else begin
                                keep = 1'b1;
                            end
                        end
                        default: begin
                            n_phase = r_phase;
                        end
                    endcase

                    fill_base = clear ? 2'd0 : r_fill;
                    n_fill    = fill_base;
                    if (keep) begin
                        n_fill = (fill_base == FILL_FULL) ? FILL_FULL : fill_base + 1'b1;
                        n_last = i_q_frame[6*CB-1:0];
                        for (int k = 0; k < 6; k++) begin
                            n_diff[k] = $signed({i_q_frame[k*CB+CB-1], i_q_frame[k*CB +: CB]}) -
                                        $signed({r_last[k*CB+CB-1], r_last[k*CB +: CB]});
                        end
                        if (fill_base != 2'd0) begin
                            n_seq = SEQ_SQUARE;
                        end
                    end

                    n_out_valid = 1'b1;
                    n_out_phase = n_phase;
                    n_kept      = keep;
                end
            end
            SEQ_SQUARE: begin
                n_seq = SEQ_SUM;
            end
            SEQ_SUM: begin
                n_dist_l = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
                n_dist_r = SUM_W'(r_sq[3]) + SUM_W'(r_sq[4]) + SUM_W'(r_sq[5]);
                n_seq    = SEQ_DECIDE;
            end
            default: begin
                n_seq = SEQ_DECIDE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_WAIT_TRACK;
            r_seq        <= SEQ_DECIDE;
            r_idle       <= '0;
            r_fill       <= '0;
            r_out_valid  <= 1'b0;
            r_idle_limit <= gsf_pkg::IDLE_LIMIT_RST;
            r_thresh     <= gsf_pkg::MOTION_THR_RST;
        end else begin
            r_phase     <= n_phase;
            r_seq       <= n_seq;
            r_idle      <= n_idle;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                unique case (gsf_pkg::t_cfg_idx'(i_cfg_index))
                    gsf_pkg::CFG_IDLE_LIMIT: r_idle_limit <= i_cfg_data[IDLE_W-1:0];
                    gsf_pkg::CFG_MOTION_THR: r_thresh     <= i_cfg_data;
                    default:                 r_thresh     <= r_thresh;
                endcase
            end
        end
        r_out_phase <= n_out_phase;
        r_kept      <= n_kept;
        r_started   <= n_started;
        r_ended     <= n_ended;
        r_sent      <= n_sent;
        r_announced <= n_announced;
        r_last      <= n_last;
        r_dist_l    <= n_dist_l;
        r_dist_r    <= n_dist_r;
        for (int k = 0; k < 6; k++) begin
            r_diff[k] <= n_diff[k];
            r_sq[k]   <= n_sq[k];
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_phase           = r_out_phase;
    assign o_frame_kept      = r_kept;
    assign o_sign_started    = r_started;
    assign o_sign_ended      = r_ended;
    assign o_sentence_ended  = r_sent;
    assign o_phase_announced = r_announced;

    `ASSERT_IMPLY(a_start_records, i_clk, i_rst_n, o_out_valid && o_sign_started, (o_phase == PH_RECORD) && o_frame_kept && o_phase_announced)
    `ASSERT_IMPLY(a_sentence_close, i_clk, i_rst_n, o_out_valid && o_sentence_ended, (o_phase == PH_WAIT_READY) && o_phase_announced && !o_frame_kept)
    `ASSERT_IMPLY(a_seq_needs_full, i_clk, i_rst_n, r_seq != SEQ_DECIDE, (r_fill == FILL_FULL) && !o_q_pop)
    `ASSERT_ALWAYS(a_one_event, i_clk, i_rst_n, !o_out_valid || $onehot0({o_sign_started, o_sign_ended, o_sentence_ended}))

endmodule

// ===== rtl/gesture_segmentation_fsm_unit.sv =====
`timescale 1ns / 1ps
// Gesture segmentation unit.
// Input channel (i_in_valid / o_in_ready) takes one skeleton frame per item:
// tracking flag, hand positions, torso height and hip positions.
// Output channel (o_out_valid / i_out_ready) returns one result per item:
// phase plus kept / started / ended / sentence / announced flags.
// Config channel (i_cfg_valid / o_cfg_ready, always ready) writes index 0
// idle frame limit and index 1 squared motion threshold; write only when idle.
// An accepted input item is registered in a queue entry; when the back is free,
// the decision step then writes its result into the output register.
// Throughput: 1 item per cycle while the receiver takes results and no item is
// appended to a hand history that already holds a frame; such an item holds the
// back for the difference / square / sum pass that refreshes both hand distances.
// The two-entry queue lets the front accept while the back is busy.
// Reset: phase waits for tracking, history empty, registers at 45 and 2500.
// When the receiver stalls, the result holds in the output register, the
// queue fills and o_in_ready drops; nothing is lost.

module gesture_segmentation_fsm_unit #(
    parameter int COORD_BITS = gsf_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [gsf_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gsf_pkg::THR_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_user_tracked,
    input  logic signed [COORD_BITS-1:0]  i_left_hand_x,
    input  logic signed [COORD_BITS-1:0]  i_left_hand_y,
    input  logic signed [COORD_BITS-1:0]  i_left_hand_z,
    input  logic signed [COORD_BITS-1:0]  i_right_hand_x,
    input  logic signed [COORD_BITS-1:0]  i_right_hand_y,
    input  logic signed [COORD_BITS-1:0]  i_right_hand_z,
    input  logic signed [COORD_BITS-1:0]  i_torso_y,
    input  logic signed [COORD_BITS-1:0]  i_left_hip_x,
    input  logic signed [COORD_BITS-1:0]  i_left_hip_y,
    input  logic signed [COORD_BITS-1:0]  i_right_hip_x,
    input  logic signed [COORD_BITS-1:0]  i_right_hip_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [1:0]                    o_phase,
    output logic                          o_frame_kept,
    output logic                          o_sign_started,
    output logic                          o_sign_ended,
    output logic                          o_sentence_ended,
    output logic                          o_phase_announced
);

    localparam int FRAME_W = 6 * COORD_BITS + 2;

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_valid;
    logic [FRAME_W-1:0] front_frame;
    logic [FRAME_W-1:0] q_frame;

    assign o_cfg_ready = 1'b1;

    gsf_front #(
        .COORD_BITS(COORD_BITS)
    ) u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_user_tracked(i_user_tracked),
        .i_left_hand_x (i_left_hand_x),
        .i_left_hand_y (i_left_hand_y),
        .i_left_hand_z (i_left_hand_z),
        .i_right_hand_x(i_right_hand_x),
        .i_right_hand_y(i_right_hand_y),
        .i_right_hand_z(i_right_hand_z),
        .i_torso_y     (i_torso_y),
        .i_left_hip_x  (i_left_hip_x),
        .i_left_hip_y  (i_left_hip_y),
        .i_right_hip_x (i_right_hip_x),
        .i_right_hip_y (i_right_hip_y),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_frame       (front_frame)
    );

    gsf_queue #(
        .WIDTH(FRAME_W),
        .DEPTH(gsf_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (front_frame),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_frame)
    );

    gsf_back #(
        .COORD_BITS(COORD_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_q_valid        (q_valid),
        .i_q_frame        (q_frame),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_phase          (o_phase),
        .o_frame_kept     (o_frame_kept),
        .o_sign_started   (o_sign_started),
        .o_sign_ended     (o_sign_ended),
        .o_sentence_ended (o_sentence_ended),
        .o_phase_announced(o_phase_announced)
    );

endmodule
